// ===== sv/sbcdm_pkg.sv =====
// Shared constants, types and helpers for the signed BCD multiplier.
package sbcdm_pkg;

	localparam int DIGITS = 16;
	localparam int NIB_W  = 4;
	localparam int DATA_W = 64;
	localparam int POS_W  = $clog2(DIGITS);
	localparam int PROD_W = 2 * NIB_W;
	// widest column: DIGITS products of 15 * 15
	localparam int COL_W  = $clog2(DIGITS * 225 + 1);
	localparam int SUM_W  = 6;

	typedef logic [NIB_W-1:0]  digit_t;
	typedef logic [PROD_W-1:0] prod_t;
	typedef logic [COL_W-1:0]  col_t;
	typedef logic [SUM_W-1:0]  psum_t;

	// one column split into four decimal digits, d0 the low digit, d3 the high
	typedef struct packed {
		digit_t d3;
		digit_t d2;
		digit_t d1;
		digit_t d0;
	} coldig_t;

	// Column value (at most 3600) split into decimal digits. Quotients by
	// 10, 100 and 1000 come from reciprocal multiplies that are exact
	// over the column range.
	function automatic coldig_t col_split(input col_t col);
		logic [27:0] m10;
		logic [27:0] m100;
		logic [27:0] m1000;
		logic [8:0]  q10;
		logic [5:0]  q100;
		logic [1:0]  q1000;
		logic [11:0] r0;
		logic [8:0]  r1;
		logic [5:0]  r2;
		coldig_t     res;
		m10   = 28'(col) * 28'd6554;
		m100  = 28'(col) * 28'd5243;
		m1000 = 28'(col) * 28'd4195;
		q10   = m10[16 +: 9];
		q100  = m100[19 +: 6];
		q1000 = m1000[22 +: 2];
		r0    = 12'(col) - 12'(q10) * 12'd10;
		r1    = q10 - 9'(q100) * 9'd10;
		r2    = q100 - 6'(q1000) * 6'd10;
		res.d0 = r0[3:0];
		res.d1 = r1[3:0];
		res.d2 = r2[3:0];
		res.d3 = {2'b00, q1000};
		return res;
	endfunction

endpackage

// ===== sv/signed_bcd_multiplier_unit.sv =====
// Signed BCD multiplier: pipelined schoolbook product of two packed BCD numbers.
//
// Usage:
//   Command side: drive a_digits/a_negative/b_digits/b_negative and raise start.
//   A beat is taken at each rising edge with start high and busy low. busy is
//   always low, so a new operand pair can be taken every cycle.
//   Result side: done pulses for one cycle with p_digits/p_negative/overflow.
//   The receiver cannot hold results off; every beat must be taken as shown.
// Strobe: done is registered from the valid chain vld_s1..vld_s5, in step
//   with the result register.
// Throughput: one beat per cycle, fixed by the six-stage pipeline:
//   s1 operand register, s2 digit products, s3 column sums,
//   s4 decimal split of each column, s5 position sums folded to 0..12,
//   then the final decimal carry (one 16-bit add) into the result register.
// Overflow: when the top nonzero digit positions add past DIGITS-1, the
//   result is positive zero with overflow set.
// Reset: arst_n clears the stage valid bits; beats in flight are dropped
//   and no result strobes until new beats are taken.
module signed_bcd_multiplier_unit
	import sbcdm_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [DATA_W-1:0] a_digits,
	input  logic              a_negative,
	input  logic [DATA_W-1:0] b_digits,
	input  logic              b_negative,
	output logic              done,
	output logic [DATA_W-1:0] p_digits,
	output logic              p_negative,
	output logic              overflow
);

	// stage valid bits
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, done_q;

	// stage 1: operand register
	logic [DATA_W-1:0] a_s1, b_s1;
	logic              neg_s1;

	// stage 2: digit products
	prod_t prod_c [DIGITS][DIGITS];
	prod_t prod_s2 [DIGITS][DIGITS];
	logic  ovf_c;
	logic  ovf_s2, neg_s2;
	logic [POS_W-1:0] top_a, top_b;

	// stage 3: column sums
	col_t col_c [DIGITS];
	col_t col_s3 [DIGITS];
	logic ovf_s3, neg_s3;

	// stage 4: columns as decimal digits
	coldig_t dig_c [DIGITS];
	coldig_t dig_s4 [DIGITS];
	logic    ovf_s4, neg_s4;

	// stage 5: position values in 0..12
	digit_t v_c [DIGITS];
	digit_t v_s5 [DIGITS];
	logic   ovf_s5, neg_s5;

	// result
	logic [DIGITS-1:0] gen, prop, cin;
	logic [DIGITS-1:0] csum;
	logic [DATA_W-1:0] pd_c;
	logic [DATA_W-1:0] p_digits_q;
	logic              p_negative_q, overflow_q;
	logic              digits_ok;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			done_q <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			done_q <= vld_s5;
		end
	end

	// operand capture
	always_ff @(posedge clk) begin
		if (start && !busy) begin
			a_s1   <= a_digits;
			b_s1   <= b_digits;
			neg_s1 <= a_negative ^ b_negative;
		end
	end

	// top nonzero digit position of each operand; zero counts as position 0
	always_comb begin
		top_a = '0;
		top_b = '0;
		for (int i = 0; i < DIGITS; i++) begin
			if (a_s1[NIB_W*i +: NIB_W] != '0) top_a = POS_W'(i);
			if (b_s1[NIB_W*i +: NIB_W] != '0) top_b = POS_W'(i);
		end
		ovf_c = ({1'b0, top_a} + {1'b0, top_b}) > (POS_W+1)'(DIGITS - 1);
	end

	// digit products; terms that land at or above DIGITS are dropped
	always_comb begin
		for (int i = 0; i < DIGITS; i++) begin
			for (int j = 0; j < DIGITS; j++) begin
				if (i + j < DIGITS)
					prod_c[i][j] = prod_t'(a_s1[NIB_W*i +: NIB_W])
					             * prod_t'(b_s1[NIB_W*j +: NIB_W]);
				else
					prod_c[i][j] = '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		prod_s2 <= prod_c;
		ovf_s2  <= ovf_c;
		neg_s2  <= neg_s1;
	end

	// column k gathers a[i] * b[k-i]
	always_comb begin
		for (int k = 0; k < DIGITS; k++) begin
			col_c[k] = '0;
			for (int i = 0; i <= k; i++)
				col_c[k] = col_c[k] + col_t'(prod_s2[i][k-i]);
		end
	end

	always_ff @(posedge clk) begin
		col_s3 <= col_c;
		ovf_s3 <= ovf_s2;
		neg_s3 <= neg_s2;
	end

	always_comb begin
		for (int k = 0; k < DIGITS; k++)
			dig_c[k] = col_split(col_s3[k]);
	end

	always_ff @(posedge clk) begin
		dig_s4 <= dig_c;
		ovf_s4 <= ovf_s3;
		neg_s4 <= neg_s3;
	end

	// position sum (at most 30), split into units and tens, tens moved up
	always_comb begin
		psum_t  s    [DIGITS];
		logic [1:0] tens [DIGITS];
		digit_t unit [DIGITS];
		for (int k = 0; k < DIGITS; k++) begin
			s[k] = psum_t'(dig_s4[k].d0);
			if (k >= 1) s[k] = s[k] + psum_t'(dig_s4[k-1].d1);
			if (k >= 2) s[k] = s[k] + psum_t'(dig_s4[k-2].d2);
			if (k >= 3) s[k] = s[k] + psum_t'(dig_s4[k-3].d3);
			if (s[k] >= psum_t'(30))      tens[k] = 2'd3;
			else if (s[k] >= psum_t'(20)) tens[k] = 2'd2;
			else if (s[k] >= psum_t'(10)) tens[k] = 2'd1;
			else                          tens[k] = 2'd0;
			unit[k] = NIB_W'(s[k] - psum_t'(tens[k]) * psum_t'(10));
		end
		for (int k = 0; k < DIGITS; k++) begin
			if (k == 0) v_c[k] = unit[k];
			else        v_c[k] = unit[k] + digit_t'(tens[k-1]);
		end
	end

	always_ff @(posedge clk) begin
		v_s5   <= v_c;
		ovf_s5 <= ovf_s4;
		neg_s5 <= neg_s4;
	end

	// final decimal carry: generate at >= 10, propagate at 9, resolved
	// by one binary add of (g|p) and g; the top carry is dropped
	always_comb begin
		for (int k = 0; k < DIGITS; k++) begin
			gen[k]  = v_s5[k] >= digit_t'(10);
			prop[k] = v_s5[k] == digit_t'(9);
		end
		csum = (gen | prop) + gen;
		cin  = csum ^ prop;
		pd_c = '0;
		for (int k = 0; k < DIGITS; k++) begin
			digit_t t;
			t = v_s5[k] + digit_t'(cin[k]);
			if (t >= digit_t'(10)) t = t - digit_t'(10);
			pd_c[NIB_W*k +: NIB_W] = t;
		end
	end

	always_ff @(posedge clk) begin
		p_digits_q   <= ovf_s5 ? '0 : pd_c;
		p_negative_q <= neg_s5 && !ovf_s5;
		overflow_q   <= ovf_s5;
	end

	assign done       = done_q;
	assign p_digits   = p_digits_q;
	assign p_negative = p_negative_q;
	assign overflow   = overflow_q;

	// every result nibble is a decimal digit
	always_comb begin
		digits_ok = 1'b1;
		for (int k = 0; k < DATA_W / NIB_W; k++)
			if (p_digits[NIB_W*k +: NIB_W] > digit_t'(9)) digits_ok = 1'b0;
	end

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##6 done)
		else $error("result strobe missing six cycles after accept");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 6))
		else $error("result strobe without matching accept");

	a_ovf_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && overflow |-> p_digits == '0 && !p_negative)
		else $error("overflow result not positive zero");

	a_decimal: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> digits_ok)
		else $error("product digit outside 0..9");

endmodule
